// ===== rtl/cds_pkg.sv =====
//------------------------------------------------------------------------------
// cds_pkg
// Shared constants, register codes and lane control types of the smoother.
//------------------------------------------------------------------------------
package cds_pkg;

    localparam int CHANNELS   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_W      = 64;
    localparam int DIV_STEP_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED   = 2'd1;

    localparam logic [30:0] ST_RESET = 31'd65536;
    localparam logic [30:0] MS_RESET = 31'h7FFF_FFFF;
    localparam logic [30:0] ST_FLOOR = 31'd7;

    localparam logic [26:0] X_CAP  = 27'h400_0000;
    localparam logic [14:0] K_SQ   = 15'd31457;
    localparam logic [13:0] K_CU   = 14'd15401;
    localparam logic [34:0] MC_CAP = 35'h4_0000_0000;

    localparam logic [47:0] SAT_LIM = 48'h7FFF_FFFF_FFFF;
    localparam logic [63:0] DOT_LIM = 64'h2000_0000_0000_0000;

    // dividend 1 aligned to the top bit; steps pick 2^33 or 2^48
    localparam logic [DIV_W-1:0]      DIV_TOP_ONE = 64'h8000_0000_0000_0000;
    localparam logic [DIV_STEP_W-1:0] OMEGA_STEPS = 7'd34;
    localparam logic [DIV_STEP_W-1:0] DECAY_STEPS = 7'd49;
    localparam logic [DIV_STEP_W-1:0] QUOT_STEPS  = 7'd64;

    typedef struct packed {
        logic start_chg;
        logic start_run;
        logic limit;
    } t_lane_ctl;

    typedef struct packed {
        logic done;
    } t_lane_sts;

endpackage

// ===== rtl/cds_cfg_if.sv =====
//------------------------------------------------------------------------------
// cds_cfg_if
// Register write channel: index and data with valid/ready.
//------------------------------------------------------------------------------
interface cds_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cds_pkg::CFG_IDX_W-1:0]  index;
    logic [30:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/cds_item_if.sv =====
//------------------------------------------------------------------------------
// cds_item_if
// Input item channel: channel, current and target position, time step.
//------------------------------------------------------------------------------
interface cds_item_if;
    logic               valid;
    logic               ready;
    logic [3:0]         channel;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_z;
    logic [30:0]        time_step;

    modport source (output valid, output channel, output cur_x, output cur_y,
                    output cur_z, output goal_x, output goal_y, output goal_z,
                    output time_step, input ready);
    modport sink   (input valid, input channel, input cur_x, input cur_y,
                    input cur_z, input goal_x, input goal_y, input goal_z,
                    input time_step, output ready);
endinterface

// ===== rtl/cds_result_if.sv =====
//------------------------------------------------------------------------------
// cds_result_if
// Result channel: smoothed position and snap flag.
//------------------------------------------------------------------------------
interface cds_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               snapped;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output snapped, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input snapped, output ready);
endinterface

// ===== rtl/cds_ram.sv =====
//------------------------------------------------------------------------------
// cds_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
module cds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cds_div.sv =====
//------------------------------------------------------------------------------
// cds_div
// Restoring divider, one quotient bit per cycle over a chosen step count.
//------------------------------------------------------------------------------
module cds_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [cds_pkg::DIV_W-1:0]         i_dividend,
    input  logic [cds_pkg::DIV_W-1:0]         i_divisor,
    input  logic [cds_pkg::DIV_STEP_W-1:0]    i_steps,
    output logic                              o_done,
    output logic [cds_pkg::DIV_W-1:0]         o_quot
);

    logic                           r_busy;
    logic                           r_done;
    logic [cds_pkg::DIV_STEP_W-1:0] r_cnt;
    logic [cds_pkg::DIV_W-1:0]      r_num;
    logic [cds_pkg::DIV_W-1:0]      r_rem;
    logic [cds_pkg::DIV_W-1:0]      r_den;
    logic [cds_pkg::DIV_W-1:0]      r_quo;
    logic [cds_pkg::DIV_W:0]        rem_sh;
    logic                           fits;

    assign rem_sh = {r_rem, r_num[cds_pkg::DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[cds_pkg::DIV_W-2:0], 1'b0};
            r_rem <= fits ? cds_pkg::DIV_W'(rem_sh - {1'b0, r_den})
                          : rem_sh[cds_pkg::DIV_W-1:0];
            r_quo <= {r_quo[cds_pkg::DIV_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== rtl/cds_isqrt.sv =====
//------------------------------------------------------------------------------
// cds_isqrt
// Integer square root of a 64-bit value, one result bit per cycle.
//------------------------------------------------------------------------------
module cds_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic [63:0] trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_r   <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[31:0];

endmodule

// ===== rtl/cds_lane.sv =====
//------------------------------------------------------------------------------
// cds_lane
// One axis of the smoother: change, distance limit, spring update and the
// overshoot term, on a two-step 48x33 multiplier and its own divider.
//------------------------------------------------------------------------------
module cds_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cds_pkg::t_lane_ctl    i_ctl,
    output cds_pkg::t_lane_sts    o_sts,
    input  logic signed [31:0]    i_cur,
    input  logic signed [31:0]    i_goal,
    input  logic signed [31:0]    i_vel,
    input  logic [30:0]           i_omega,
    input  logic [30:0]           i_dt,
    input  logic [32:0]           i_e,
    input  logic [31:0]           i_mc,
    input  logic [31:0]           i_len,
    output logic [58:0]           o_m2,
    output logic signed [47:0]    o_pos,
    output logic signed [47:0]    o_vel,
    output logic signed [62:0]    o_dot
);

    typedef enum logic [3:0] {
        L_IDLE, L_SQ, L_HOLD, L_SETUP, L_LO, L_HI, L_FIN, L_POST, L_DIVW, L_DONE
    } t_lstate;

    typedef enum logic [2:0] {
        OP_LIM, OP_A, OP_T, OP_U, OP_V, OP_P, OP_D
    } t_op;

    typedef enum logic [1:0] {SH0, SH16, SH32} t_sh;
    typedef enum logic [1:0] {LIM_SAT, LIM_DOT, LIM_NONE} t_lim;

    localparam logic signed [65:0] SAT_HI = 66'(cds_pkg::SAT_LIM);
    localparam logic signed [65:0] SAT_LO = -SAT_HI;

    t_lstate            r_state;
    t_op                r_op;
    t_sh                r_sh;
    t_lim               r_lim;
    logic signed [32:0] r_chg;
    logic [58:0]        r_m2;
    logic signed [47:0] r_s;
    logic signed [47:0] r_t;
    logic signed [47:0] r_vn;
    logic signed [47:0] r_o;
    logic signed [62:0] r_dot;
    logic [47:0]        r_ma;
    logic [32:0]        r_mb;
    logic               r_neg;
    logic [80:0]        r_acc;
    logic signed [64:0] r_res;

    logic [32:0]        chg_mag;
    logic [59:0]        sq;
    logic signed [32:0] d_gc;
    logic signed [48:0] d_og;
    logic [32:0]        gc_mag;
    logic [48:0]        og_mag;
    logic [47:0]        s_mag;
    logic [47:0]        t_mag;
    logic [56:0]        pp_lo;
    logic [56:0]        pp_hi;
    logic [80:0]        shifted;
    logic [80:0]        lim_val;
    logic [63:0]        res_mag;
    logic               div_start;
    logic               div_done;
    logic [63:0]        div_quot;
    logic signed [32:0] q_s;

    function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
        if (v > SAT_HI) return SAT_HI[47:0];
        if (v < SAT_LO) return SAT_LO[47:0];
        return v[47:0];
    endfunction

    assign chg_mag = r_chg[32] ? 33'(-r_chg) : 33'(r_chg);
    assign sq      = chg_mag[32:3] * chg_mag[32:3];
    assign d_gc    = 33'(i_goal) - 33'(i_cur);
    assign d_og    = 49'(r_o) - 49'(i_goal);
    assign gc_mag  = d_gc[32] ? 33'(-d_gc) : 33'(d_gc);
    assign og_mag  = d_og[48] ? 49'(-d_og) : 49'(d_og);
    assign s_mag   = r_s[47] ? 48'(-r_s) : 48'(r_s);
    assign t_mag   = r_t[47] ? 48'(-r_t) : 48'(r_t);
    assign pp_lo   = r_ma[23:0] * r_mb;
    assign pp_hi   = r_ma[47:24] * r_mb;
    assign q_s     = $signed(div_quot[32:0]);

    always_comb begin
        case (r_sh)
            SH16:    shifted = r_acc >> 16;
            SH32:    shifted = r_acc >> 32;
            default: shifted = r_acc;
        endcase
        case (r_lim)
            LIM_SAT: lim_val = 81'(cds_pkg::SAT_LIM);
            LIM_DOT: lim_val = 81'(cds_pkg::DOT_LIM);
            default: lim_val = 81'(64'hFFFF_FFFF_FFFF_FFFF);
        endcase
        res_mag = (shifted > lim_val) ? lim_val[63:0] : shifted[63:0];
    end

    assign div_start = (r_state == L_POST) && (r_op == OP_LIM);

    cds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_res[63:0]),
        .i_divisor  ({32'b0, i_len}),
        .i_steps    (cds_pkg::QUOT_STEPS),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_op    <= OP_A;
        end else begin
            case (r_state)
                L_IDLE, L_DONE: begin
                    if (i_ctl.start_chg) begin
                        r_chg   <= 33'(i_cur) - 33'(i_goal);
                        r_state <= L_SQ;
                    end
                end
                L_SQ: begin
                    r_m2    <= sq[58:0];
                    r_state <= L_HOLD;
                end
                L_HOLD: begin
                    if (i_ctl.start_run) begin
                        r_op    <= i_ctl.limit ? OP_LIM : OP_A;
                        r_state <= L_SETUP;
                    end
                end
                L_SETUP: begin
                    case (r_op)
                        OP_LIM: begin
                            r_ma <= 48'(chg_mag); r_mb <= {1'b0, i_mc};
                            r_neg <= 1'b0; r_sh <= SH0; r_lim <= LIM_NONE;
                        end
                        OP_A: begin
                            r_ma <= 48'(chg_mag); r_mb <= {2'b0, i_omega};
                            r_neg <= r_chg[32]; r_sh <= SH16; r_lim <= LIM_SAT;
                        end
                        OP_T: begin
                            r_ma <= s_mag; r_mb <= {2'b0, i_dt};
                            r_neg <= r_s[47]; r_sh <= SH16; r_lim <= LIM_SAT;
                        end
                        OP_U: begin
                            r_ma <= t_mag; r_mb <= {2'b0, i_omega};
                            r_neg <= r_t[47]; r_sh <= SH16; r_lim <= LIM_SAT;
                        end
                        OP_V, OP_P: begin
                            r_ma <= s_mag; r_mb <= i_e;
                            r_neg <= r_s[47]; r_sh <= SH32; r_lim <= LIM_SAT;
                        end
                        default: begin
                            r_ma <= og_mag[47:0]; r_mb <= gc_mag;
                            r_neg <= d_gc[32] ^ d_og[48]; r_sh <= SH0; r_lim <= LIM_DOT;
                        end
                    endcase
                    r_state <= L_LO;
                end
                L_LO: begin
                    r_acc   <= 81'(pp_lo);
                    r_state <= L_HI;
                end
                L_HI: begin
                    r_acc   <= r_acc + (81'(pp_hi) << 24);
                    r_state <= L_FIN;
                end
                L_FIN: begin
                    r_res   <= r_neg ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
                    r_state <= L_POST;
                end
                L_POST: begin
                    case (r_op)
                        OP_LIM: r_state <= L_DIVW;
                        OP_A: begin
                            r_s     <= sat48(66'(i_vel) + 66'(r_res));
                            r_op    <= OP_T;
                            r_state <= L_SETUP;
                        end
                        OP_T: begin
                            r_t     <= r_res[47:0];
                            r_op    <= OP_U;
                            r_state <= L_SETUP;
                        end
                        OP_U: begin
                            r_s     <= sat48(66'(i_vel) - 66'(r_res));
                            r_op    <= OP_V;
                            r_state <= L_SETUP;
                        end
                        OP_V: begin
                            r_vn    <= r_res[47:0];
                            r_s     <= sat48(66'(r_chg) + 66'(r_t));
                            r_op    <= OP_P;
                            r_state <= L_SETUP;
                        end
                        OP_P: begin
                            r_o     <= sat48(66'(i_cur) - 66'(r_chg) + 66'(r_res));
                            r_op    <= OP_D;
                            r_state <= L_SETUP;
                        end
                        default: begin
                            r_dot   <= r_res[62:0];
                            r_state <= L_DONE;
                        end
                    endcase
                end
                L_DIVW: begin
                    if (div_done) begin
                        r_chg   <= r_chg[32] ? -q_s : q_s;
                        r_op    <= OP_A;
                        r_state <= L_SETUP;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_sts.done = (r_state == L_DONE);
    assign o_m2       = r_m2;
    assign o_pos      = r_o;
    assign o_vel      = r_vn;
    assign o_dot      = r_dot;

endmodule

// ===== rtl/critically_damped_smoother_core.sv =====
//------------------------------------------------------------------------------
// critically_damped_smoother_core
// Per-channel critically damped spring smoother on 3-D Q16.16 positions.
//------------------------------------------------------------------------------
// One item at a time. Each item runs a 34-step division for omega and a 49-step
// division for the decay factor on the shared divider, a chain of single
// multiplies, then three axis lanes in parallel, each doing six multiplies;
// when the distance limit engages, it adds a 32-step square root in the core
// and a further multiply and a 64-step divide in each lane.
// Velocities sit in one RAM with a valid bit per channel, so reset clears
// them at once. Input is taken while a finished result waits at the output.
//------------------------------------------------------------------------------
module critically_damped_smoother_core #(
    parameter int CHANNELS = cds_pkg::CHANNELS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cds_cfg_if.sink       i_cfg,
    cds_item_if.sink      i_item,
    cds_result_if.source  o_result
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_VREAD, S_OMEGA, S_MX, S_MX2, S_MX3, S_MK2, S_MK3,
        S_ESTART, S_EDIV, S_MC, S_D2, S_LIMC, S_SQRT, S_LANES, S_OUT
    } t_state;

    function automatic logic [IDX_W-1:0] chan_wrap(input logic [3:0] ch);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int k = 0; k < 16; k++) begin
            if (ch == 4'(k)) r = IDX_W'(k % CHANNELS);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -48'sh0000_8000_0000) return -32'sh8000_0000;
        return v[31:0];
    endfunction

    t_state              r_state;
    logic [30:0]         r_smooth_time;
    logic [30:0]         r_max_speed;
    logic [IDX_W-1:0]    r_idx;
    logic [CHANNELS-1:0] r_vld;
    logic signed [31:0]  r_cur  [3];
    logic signed [31:0]  r_goal [3];
    logic signed [31:0]  r_vel  [3];
    logic [30:0]         r_dt;
    logic [30:0]         r_st;
    logic [30:0]         r_omega;
    logic [26:0]         r_x;
    logic [36:0]         r_x2;
    logic [46:0]         r_x3;
    logic [35:0]         r_t2;
    logic [47:0]         r_den;
    logic [32:0]         r_e;
    logic [31:0]         r_mc;
    logic [59:0]         r_d2;
    logic [31:0]         r_len;
    logic signed [63:0]  r_dotsum;
    cds_pkg::t_lane_ctl  r_ctl;
    logic                r_ovalid;
    logic signed [31:0]  r_out [3];
    logic                r_snapped;

    cds_pkg::t_lane_sts  lane_sts [3];
    logic [58:0]         lane_m2  [3];
    logic signed [47:0]  lane_pos [3];
    logic signed [47:0]  lane_vn  [3];
    logic signed [62:0]  lane_dot [3];

    logic                in_xfer;
    logic                slot_free;
    logic                div_start;
    logic [63:0]         div_divisor;
    logic [6:0]          div_steps;
    logic                div_done;
    logic [63:0]         div_quot;
    logic                sq_start;
    logic                sq_done;
    logic [31:0]         sq_root;
    logic [95:0]         ram_rdata;
    logic [95:0]         ram_wdata;
    logic                ram_we;
    logic                snap;
    logic signed [31:0]  vel_wr [3];

    logic [61:0]         p_om_dt;
    logic [53:0]         p_xx;
    logic [63:0]         p_x3;
    logic [51:0]         p_k2;
    logic [60:0]         p_k3;
    logic [61:0]         p_ms;
    logic [34:0]         mc_full;
    logic [63:0]         mc_sq;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = (r_state == S_IDLE);
    assign in_xfer      = i_item.valid && (r_state == S_IDLE);
    assign slot_free    = !r_ovalid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth_time <= cds_pkg::ST_RESET;
            r_max_speed   <= cds_pkg::MS_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                cds_pkg::REG_SMOOTH_TIME: r_smooth_time <= i_cfg.data;
                cds_pkg::REG_MAX_SPEED:   r_max_speed   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign p_om_dt = r_omega * r_dt;
    assign p_xx    = r_x * r_x;
    assign p_x3    = r_x2 * r_x;
    assign p_k2    = cds_pkg::K_SQ * r_x2;
    assign p_k3    = cds_pkg::K_CU * r_x3;
    assign p_ms    = r_max_speed * r_st;
    assign mc_full = (p_ms[61:16] > 46'(cds_pkg::MC_CAP)) ? cds_pkg::MC_CAP
                                                        : p_ms[50:16];
    assign mc_sq   = r_mc * r_mc;

    assign div_start   = (r_state == S_VREAD) || (r_state == S_ESTART);
    assign div_divisor = (r_state == S_VREAD) ? {33'b0, r_st} : {16'b0, r_den};
    assign div_steps   = (r_state == S_VREAD) ? cds_pkg::OMEGA_STEPS
                                              : cds_pkg::DECAY_STEPS;
    assign sq_start    = (r_state == S_LIMC) && (64'(r_d2) > mc_sq);

    cds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (cds_pkg::DIV_TOP_ONE),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    cds_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (64'(r_d2)),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    for (genvar g = 0; g < 3; g++) begin : g_lane
        cds_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (r_ctl),
            .o_sts   (lane_sts[g]),
            .i_cur   (r_cur[g]),
            .i_goal  (r_goal[g]),
            .i_vel   (r_vel[g]),
            .i_omega (r_omega),
            .i_dt    (r_dt),
            .i_e     (r_e),
            .i_mc    (r_mc),
            .i_len   (r_len),
            .o_m2    (lane_m2[g]),
            .o_pos   (lane_pos[g]),
            .o_vel   (lane_vn[g]),
            .o_dot   (lane_dot[g])
        );
    end

    assign snap   = (r_dotsum > 64'sd0);
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            vel_wr[a] = snap ? 32'sd0 : sat32(lane_vn[a]);
        end
    end
    assign ram_we    = (r_state == S_OUT) && slot_free;
    assign ram_wdata = {vel_wr[2], vel_wr[1], vel_wr[0]};

    cds_ram #(
        .WIDTH (96),
        .DEPTH (CHANNELS)
    ) u_vel_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (chan_wrap(i_item.channel)),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ctl    <= '0;
            r_ovalid <= 1'b0;
            r_vld    <= '0;
        end else begin
            r_ctl.start_chg <= in_xfer;
            r_ctl.start_run <= ((r_state == S_LIMC) && !sq_start) ||
                               ((r_state == S_SQRT) && sq_done);
            if (r_ovalid && o_result.ready && !ram_we) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_idx     <= chan_wrap(i_item.channel);
                        r_cur[0]  <= i_item.cur_x;
                        r_cur[1]  <= i_item.cur_y;
                        r_cur[2]  <= i_item.cur_z;
                        r_goal[0] <= i_item.goal_x;
                        r_goal[1] <= i_item.goal_y;
                        r_goal[2] <= i_item.goal_z;
                        r_dt      <= i_item.time_step;
                        r_st      <= (r_smooth_time < cds_pkg::ST_FLOOR) ?
                                     cds_pkg::ST_FLOOR : r_smooth_time;
                        r_state   <= S_VREAD;
                    end
                end
                S_VREAD: begin
                    r_vel[0] <= r_vld[r_idx] ? ram_rdata[31:0]  : 32'sd0;
                    r_vel[1] <= r_vld[r_idx] ? ram_rdata[63:32] : 32'sd0;
                    r_vel[2] <= r_vld[r_idx] ? ram_rdata[95:64] : 32'sd0;
                    r_state  <= S_OMEGA;
                end
                S_OMEGA: begin
                    if (div_done) begin
                        r_omega <= div_quot[30:0];
                        r_state <= S_MX;
                    end
                end
                S_MX: begin
                    r_x     <= (p_om_dt[61:16] > 46'(cds_pkg::X_CAP)) ? cds_pkg::X_CAP
                                                                     : p_om_dt[42:16];
                    r_state <= S_MX2;
                end
                S_MX2: begin
                    r_x2    <= p_xx[52:16];
                    r_state <= S_MX3;
                end
                S_MX3: begin
                    r_x3    <= p_x3[62:16];
                    r_state <= S_MK2;
                end
                S_MK2: begin
                    r_t2    <= p_k2[51:16];
                    r_state <= S_MK3;
                end
                S_MK3: begin
                    r_den   <= 48'd65536 + 48'(r_x) + 48'(r_t2) + 48'(p_k3[60:16]);
                    r_state <= S_ESTART;
                end
                S_ESTART: r_state <= S_EDIV;
                S_EDIV: begin
                    if (div_done) begin
                        r_e     <= div_quot[32:0];
                        r_state <= S_MC;
                    end
                end
                S_MC: begin
                    r_mc    <= mc_full[34:3];
                    r_state <= S_D2;
                end
                S_D2: begin
                    r_d2    <= 60'(lane_m2[0]) + 60'(lane_m2[1]) + 60'(lane_m2[2]);
                    r_state <= S_LIMC;
                end
                S_LIMC: begin
                    if (sq_start) begin
                        r_ctl.limit <= 1'b1;
                        r_state     <= S_SQRT;
                    end else begin
                        r_ctl.limit <= 1'b0;
                        r_state     <= S_LANES;
                    end
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_len   <= sq_root;
                        r_state <= S_LANES;
                    end
                end
                S_LANES: begin
                    if (lane_sts[0].done && lane_sts[1].done && lane_sts[2].done) begin
                        r_dotsum <= 64'(lane_dot[0]) + 64'(lane_dot[1]) + 64'(lane_dot[2]);
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (slot_free) begin
                        for (int a = 0; a < 3; a++) begin
                            r_out[a] <= snap ? r_goal[a] : sat32(lane_pos[a]);
                        end
                        r_snapped    <= snap;
                        r_ovalid     <= 1'b1;
                        r_vld[r_idx] <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid   = r_ovalid;
    assign o_result.out_x   = r_out[0];
    assign o_result.out_y   = r_out[1];
    assign o_result.out_z   = r_out[2];
    assign o_result.snapped = r_snapped;

endmodule
